@@ src/cetl_pkg.sv @@
// Package for the preprocessor expression lexer: token, operator and error
// codes, the lexer state type and the result record. No dependencies.
`default_nettype none
package cetl_pkg;

	localparam logic [2:0] K_IDENT  = 3'd0;
	localparam logic [2:0] K_NUMBER = 3'd1;
	localparam logic [2:0] K_STRING = 3'd2;
	localparam logic [2:0] K_CHAR   = 3'd3;
	localparam logic [2:0] K_OP     = 3'd4;
	localparam logic [2:0] K_HEADER = 3'd5;
	localparam logic [2:0] K_ERROR  = 3'd6;

	localparam logic [4:0] OP_OROR     = 5'd0;
	localparam logic [4:0] OP_ANDAND   = 5'd1;
	localparam logic [4:0] OP_OR       = 5'd2;
	localparam logic [4:0] OP_AND      = 5'd3;
	localparam logic [4:0] OP_NOT      = 5'd4;
	localparam logic [4:0] OP_NE       = 5'd5;
	localparam logic [4:0] OP_EQEQ     = 5'd6;
	localparam logic [4:0] OP_ASSIGN   = 5'd7;
	localparam logic [4:0] OP_LT       = 5'd8;
	localparam logic [4:0] OP_LE       = 5'd9;
	localparam logic [4:0] OP_SHL      = 5'd10;
	localparam logic [4:0] OP_GT       = 5'd11;
	localparam logic [4:0] OP_GE       = 5'd12;
	localparam logic [4:0] OP_SHR      = 5'd13;
	localparam logic [4:0] OP_PLUS     = 5'd14;
	localparam logic [4:0] OP_MINUS    = 5'd15;
	localparam logic [4:0] OP_HASH     = 5'd16;
	localparam logic [4:0] OP_HASHHASH = 5'd17;
	localparam logic [4:0] OP_DOT      = 5'd18;
	localparam logic [4:0] OP_DOTS     = 5'd19;
	localparam logic [4:0] OP_STAR     = 5'd20;
	localparam logic [4:0] OP_SLASH    = 5'd21;
	localparam logic [4:0] OP_PERCENT  = 5'd22;
	localparam logic [4:0] OP_LPAREN   = 5'd23;
	localparam logic [4:0] OP_RPAREN   = 5'd24;
	localparam logic [4:0] OP_QUEST    = 5'd25;
	localparam logic [4:0] OP_COLON    = 5'd26;
	localparam logic [4:0] OP_COMMA    = 5'd27;
	localparam logic [4:0] OP_OTHER    = 5'd28;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_DIGIT89 = 3'd1;
	localparam logic [2:0] E_BARE0X  = 3'd2;
	localparam logic [2:0] E_INCR    = 3'd3;
	localparam logic [2:0] E_DECR    = 3'd4;
	localparam logic [2:0] E_UNTERM  = 3'd5;

	localparam logic [2:0] REG_INCLUDE_MODE = 3'd0;

	localparam int unsigned OUTQ_DEPTH = 4;

	typedef enum logic [4:0] {
		S_IDLE, S_IDENT, S_NUM0, S_0X, S_DEC, S_OCT, S_HEX, S_SUF1, S_SUF2,
		S_VBAR, S_AMP, S_BANG, S_EQ, S_LESS, S_MORE, S_PLUS, S_MINUS,
		S_STR, S_ESC, S_XESC, S_SHARP, S_DOT, S_DOT2
	} lex_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  op;
		logic [31:0] num;
		logic [7:0]  chv;
		logic [2:0]  err;
		logic        last;
	} result_t;

	function automatic result_t mk_res(logic [2:0] kind, logic [4:0] op,
			logic [31:0] num, logic [7:0] chv, logic [2:0] err);
		result_t r;
		r.kind = kind;
		r.op   = op;
		r.num  = num;
		r.chv  = chv;
		r.err  = err;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] v;
		if (c >= "0" && c <= "9") v = c - 8'h30;
		else if (c >= "a" && c <= "f") v = c - 8'h57;
		else v = c - 8'h37;
		return v[3:0];
	endfunction

endpackage
`default_nettype wire

@@ src/c_expression_token_lexer_unit.sv @@
// Top level of the preprocessor expression lexer: config register, lexer
// stage and result queue. Depends on cetl_pkg, cetl_lex, cetl_outq.
//
//   channel   direction  signals
//   input     in         in_valid, in_ready, char_code
//   result    out        out_valid, out_ready, token_kind..last
//   config    in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One character a cycle while the result queue has room; a result is offered
// after its character has passed the input register and then the result queue.
// A two-result character takes one step; the queue drains one per out_ready cycle.
// Input stalls only when the four-entry result queue has fewer than two free slots.
// Reset clears lexer state, queue and include_mode; no clearing pass.
`default_nettype none
module c_expression_token_lexer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       token_kind,
	output logic [4:0]       op_code,
	output logic [31:0]      number_value,
	output logic signed [7:0] char_value,
	output logic [2:0]       error_code,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic              include_mode_q;
	logic              room;
	logic [1:0]        push_n;
	cetl_pkg::result_t res0, res1, head;

	assign pready = 1'b1;
	assign prdata = (paddr == cetl_pkg::REG_INCLUDE_MODE) ? {31'd0, include_mode_q} : 32'd0;

	// Config register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == cetl_pkg::REG_INCLUDE_MODE) begin
			include_mode_q <= pwdata[0];
		end
	end

	cetl_lex u_lex (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.include_mode (include_mode_q),
		.room         (room),
		.push_n       (push_n),
		.res0         (res0),
		.res1         (res1)
	);

	cetl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign op_code      = head.op;
	assign number_value = head.num;
	assign char_value   = head.chv;
	assign error_code   = head.err;
	assign last         = head.last;

endmodule
`default_nettype wire

@@ src/cetl_lex.sv @@
// Lexer stage: input register, lexer state and one-character step logic.
// Depends on cetl_pkg.
`default_nettype none
module cetl_lex (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      char_code,
	input  wire logic            include_mode,
	input  wire logic            room,
	output logic [1:0]           push_n,
	output cetl_pkg::result_t    res0,
	output cetl_pkg::result_t    res1
);

	typedef struct packed {
		logic                 emit;
		cetl_pkg::result_t    res;
		cetl_pkg::lex_state_t ns;
		logic                 set_lpc;
	} str_out_t;

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 fire;
	cetl_pkg::lex_state_t state_q, ns;
	logic [31:0]          acc_q, nacc;
	logic                 qd_q, nqd;
	logic [7:0]           lpc_q, nlpc;
	logic                 skip_q, nskip;
	logic                 e1, e2, relex;
	cetl_pkg::result_t    r1, r2;
	logic [7:0]           c;

	// Character handling inside a quoted literal
	function automatic str_out_t str_char(logic [7:0] ch, logic qd, logic [7:0] lpc);
		str_out_t o;
		o.emit = 1'b0;
		o.res = cetl_pkg::mk_res(cetl_pkg::K_STRING, 5'd0, 32'd0, 8'd0, cetl_pkg::E_NONE);
		o.ns = cetl_pkg::S_STR;
		o.set_lpc = 1'b0;
		if (ch == "\"") begin
			if (qd) begin
				o.emit = 1'b1;
				o.ns = cetl_pkg::S_IDLE;
			end
		end else if (ch == "'") begin
			if (!qd) begin
				o.emit = 1'b1;
				o.res = cetl_pkg::mk_res(cetl_pkg::K_CHAR, 5'd0, 32'd0, lpc, cetl_pkg::E_NONE);
				o.ns = cetl_pkg::S_IDLE;
			end
		end else if (ch == "\\") begin
			o.ns = cetl_pkg::S_ESC;
		end else if (ch == 8'd0) begin
			o.emit = 1'b1;
			o.res = cetl_pkg::mk_res(cetl_pkg::K_ERROR, 5'd0, 32'd0, 8'd0, cetl_pkg::E_UNTERM);
			o.ns = cetl_pkg::S_IDLE;
		end else begin
			o.set_lpc = 1'b1;
		end
		return o;
	endfunction

	assign c = char_s1;
	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	// Hold the accepted character until the step can push its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	// One step: token continuation, then a second pass from idle if needed
	always_comb begin
		str_out_t so;
		ns = state_q;
		nacc = acc_q;
		nqd = qd_q;
		nlpc = lpc_q;
		nskip = skip_q;
		e1 = 1'b0;
		e2 = 1'b0;
		relex = 1'b0;
		r1 = cetl_pkg::mk_res(cetl_pkg::K_OP, 5'd0, 32'd0, 8'd0, cetl_pkg::E_NONE);
		r2 = r1;
		so = str_char(c, qd_q, lpc_q);
		if (skip_q) begin
			if (c == 8'd0) nskip = 1'b0;
		end else begin
			case (state_q)
				cetl_pkg::S_IDENT: begin
					if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
						(c >= "0" && c <= "9") || c == "_") begin
						ns = cetl_pkg::S_IDENT;
					end else if (c == "\"" || c == "'") begin
						ns = cetl_pkg::S_STR;
						nqd = (c == "\"");
						nlpc = 8'hFF;
					end else begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_IDENT;
						ns = cetl_pkg::S_IDLE;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_NUM0: begin
					if (c == "x" || c == "X") begin
						nacc = 32'd0;
						ns = cetl_pkg::S_0X;
					end else if (c >= "0" && c <= "7") begin
						nacc = {29'd0, c[2:0]};
						ns = cetl_pkg::S_OCT;
					end else if (c == "8" || c == "9") begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_ERROR;
						r1.err = cetl_pkg::E_DIGIT89;
						ns = cetl_pkg::S_IDLE;
						nskip = 1'b1;
					end else begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_NUMBER;
						r1.num = acc_q;
						ns = cetl_pkg::S_IDLE;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_OCT: begin
					if (c >= "0" && c <= "7") begin
						nacc = {acc_q[28:0], c[2:0]};
					end else begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_NUMBER;
						r1.num = acc_q;
						ns = cetl_pkg::S_IDLE;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_0X: begin
					if (cetl_pkg::is_hex(c)) begin
						nacc = {28'd0, cetl_pkg::hex_val(c)};
						ns = cetl_pkg::S_HEX;
					end else begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_ERROR;
						r1.err = cetl_pkg::E_BARE0X;
						ns = cetl_pkg::S_IDLE;
						nskip = (c != 8'd0);
					end
				end
				cetl_pkg::S_HEX, cetl_pkg::S_DEC: begin
					if (state_q == cetl_pkg::S_HEX && cetl_pkg::is_hex(c)) begin
						nacc = {acc_q[27:0], cetl_pkg::hex_val(c)};
					end else if (state_q == cetl_pkg::S_DEC && c >= "0" && c <= "9") begin
						nacc = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} +
							{28'd0, c[3:0]};
					end else if (c == "u" || c == "U") begin
						ns = cetl_pkg::S_SUF1;
					end else if (c == "l" || c == "L") begin
						ns = cetl_pkg::S_SUF2;
					end else begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_NUMBER;
						r1.num = acc_q;
						ns = cetl_pkg::S_IDLE;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_SUF1: begin
					if (c == "l" || c == "L") begin
						ns = cetl_pkg::S_SUF2;
					end else begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_NUMBER;
						r1.num = acc_q;
						ns = cetl_pkg::S_IDLE;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_SUF2: begin
					e1 = 1'b1;
					r1.kind = cetl_pkg::K_NUMBER;
					r1.num = acc_q;
					ns = cetl_pkg::S_IDLE;
					relex = !(c == "l" || c == "L");
				end
				cetl_pkg::S_VBAR: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "|") r1.op = cetl_pkg::OP_OROR;
					else begin
						r1.op = cetl_pkg::OP_OR;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_AMP: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "&") r1.op = cetl_pkg::OP_ANDAND;
					else begin
						r1.op = cetl_pkg::OP_AND;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_BANG: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "=") r1.op = cetl_pkg::OP_NE;
					else begin
						r1.op = cetl_pkg::OP_NOT;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_EQ: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "=") r1.op = cetl_pkg::OP_EQEQ;
					else begin
						r1.op = cetl_pkg::OP_ASSIGN;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_LESS, cetl_pkg::S_MORE: begin
					if (include_mode) begin
						if (c == ">" || c == 8'd0) begin
							e1 = 1'b1;
							r1.kind = cetl_pkg::K_HEADER;
							ns = cetl_pkg::S_IDLE;
						end
					end else begin
						e1 = 1'b1;
						ns = cetl_pkg::S_IDLE;
						if (c == "=") begin
							r1.op = (state_q == cetl_pkg::S_LESS) ?
								cetl_pkg::OP_LE : cetl_pkg::OP_GE;
						end else if (state_q == cetl_pkg::S_LESS && c == "<") begin
							r1.op = cetl_pkg::OP_SHL;
						end else if (state_q == cetl_pkg::S_MORE && c == ">") begin
							r1.op = cetl_pkg::OP_SHR;
						end else begin
							r1.op = (state_q == cetl_pkg::S_LESS) ?
								cetl_pkg::OP_LT : cetl_pkg::OP_GT;
							relex = 1'b1;
						end
					end
				end
				cetl_pkg::S_PLUS: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "+") begin
						r1.kind = cetl_pkg::K_ERROR;
						r1.err = cetl_pkg::E_INCR;
						nskip = 1'b1;
					end else begin
						r1.op = cetl_pkg::OP_PLUS;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_MINUS: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "-") begin
						r1.kind = cetl_pkg::K_ERROR;
						r1.err = cetl_pkg::E_DECR;
						nskip = 1'b1;
					end else begin
						r1.op = cetl_pkg::OP_MINUS;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_SHARP: begin
					e1 = 1'b1;
					ns = cetl_pkg::S_IDLE;
					if (c == "#") r1.op = cetl_pkg::OP_HASHHASH;
					else begin
						r1.op = cetl_pkg::OP_HASH;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_DOT: begin
					if (c == ".") ns = cetl_pkg::S_DOT2;
					else begin
						e1 = 1'b1;
						r1.op = cetl_pkg::OP_DOT;
						ns = cetl_pkg::S_IDLE;
						relex = 1'b1;
					end
				end
				cetl_pkg::S_DOT2: begin
					e1 = 1'b1;
					r1.op = cetl_pkg::OP_DOTS;
					ns = cetl_pkg::S_IDLE;
				end
				cetl_pkg::S_STR, cetl_pkg::S_XESC: begin
					if (state_q == cetl_pkg::S_XESC && cetl_pkg::is_hex(c)) begin
						ns = cetl_pkg::S_XESC;
					end else begin
						e1 = so.emit;
						r1 = so.res;
						ns = so.ns;
						if (so.set_lpc) nlpc = c;
					end
				end
				cetl_pkg::S_ESC: begin
					if (c == 8'd0) begin
						e1 = 1'b1;
						r1.kind = cetl_pkg::K_ERROR;
						r1.err = cetl_pkg::E_UNTERM;
						ns = cetl_pkg::S_IDLE;
					end else if (c == "x" || c == "X") begin
						ns = cetl_pkg::S_XESC;
					end else begin
						ns = cetl_pkg::S_STR;
					end
				end
				default: begin
					ns = cetl_pkg::S_IDLE;
					relex = 1'b1;
				end
			endcase

			// Second pass from idle
			if (relex) begin
				case (c)
					8'd0, " ", "\t": ;
					"\n": nskip = 1'b1;
					"0": begin
						nacc = 32'd0;
						ns = cetl_pkg::S_NUM0;
					end
					"|": ns = cetl_pkg::S_VBAR;
					"&": ns = cetl_pkg::S_AMP;
					"!": ns = cetl_pkg::S_BANG;
					"=": ns = cetl_pkg::S_EQ;
					"<": ns = cetl_pkg::S_LESS;
					">": ns = cetl_pkg::S_MORE;
					"+": ns = cetl_pkg::S_PLUS;
					"-": ns = cetl_pkg::S_MINUS;
					"#": ns = cetl_pkg::S_SHARP;
					".": ns = cetl_pkg::S_DOT;
					"\"", "'": begin
						ns = cetl_pkg::S_STR;
						nqd = (c == "\"");
						nlpc = 8'hFF;
					end
					"*": begin e2 = 1'b1; r2.op = cetl_pkg::OP_STAR; end
					"/": begin e2 = 1'b1; r2.op = cetl_pkg::OP_SLASH; end
					"%": begin e2 = 1'b1; r2.op = cetl_pkg::OP_PERCENT; end
					"(": begin e2 = 1'b1; r2.op = cetl_pkg::OP_LPAREN; end
					")": begin e2 = 1'b1; r2.op = cetl_pkg::OP_RPAREN; end
					"?": begin e2 = 1'b1; r2.op = cetl_pkg::OP_QUEST; end
					":": begin e2 = 1'b1; r2.op = cetl_pkg::OP_COLON; end
					",": begin e2 = 1'b1; r2.op = cetl_pkg::OP_COMMA; end
					default: begin
						if (c >= "1" && c <= "9") begin
							nacc = {28'd0, c[3:0]};
							ns = cetl_pkg::S_DEC;
						end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
							c == "_") begin
							ns = cetl_pkg::S_IDENT;
						end else begin
							e2 = 1'b1;
							r2.op = cetl_pkg::OP_OTHER;
							r2.chv = c;
						end
					end
				endcase
			end
		end
	end

	// Order the results and mark the final one
	always_comb begin
		res0 = e1 ? r1 : r2;
		res1 = r2;
		push_n = 2'd0;
		if (fire) push_n = {1'b0, e1} + {1'b0, e2};
		if (e1 && e2) res1.last = 1'b1;
		else res0.last = 1'b1;
	end

	// Advance lexer state on each processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cetl_pkg::S_IDLE;
			acc_q <= 32'd0;
			qd_q <= 1'b0;
			lpc_q <= 8'hFF;
			skip_q <= 1'b0;
		end else if (fire) begin
			state_q <= ns;
			acc_q <= nacc;
			qd_q <= nqd;
			lpc_q <= nlpc;
			skip_q <= nskip;
		end
	end

endmodule
`default_nettype wire

@@ src/cetl_outq.sv @@
// Result queue: takes up to two results a cycle, gives one per transfer.
// Depends on cetl_pkg.
`default_nettype none
module cetl_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      push_n,
	input  cetl_pkg::result_t    res0,
	input  cetl_pkg::result_t    res1,
	output logic                 room,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cetl_pkg::result_t    head
);

	localparam int unsigned AW = $clog2(cetl_pkg::OUTQ_DEPTH);

	cetl_pkg::result_t mem_q [cetl_pkg::OUTQ_DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic              pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;
	assign room = (cnt_q <= (AW+1)'(cetl_pkg::OUTQ_DEPTH - 2));
	assign head = mem_q[rd_q];

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= res0;
		if (push_n == 2'd2) mem_q[wr_q + AW'(1)] <= res1;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + AW'(push_n);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push_n) - (AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

@@ src/cetl_check.sv @@
// Port checker for the lexer top level, bound to every instance.
// Depends on cetl_pkg and c_expression_token_lexer_unit.
`default_nettype none
module cetl_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] token_kind,
	input wire logic [4:0] op_code,
	input wire logic [2:0] error_code
);

	// Hold a result until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind))
		else $error("result dropped while stalled");

	// Only errors carry an error code
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != cetl_pkg::K_ERROR |-> error_code == cetl_pkg::E_NONE)
		else $error("error code on non-error");

	// Only operators carry an operator code
	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != cetl_pkg::K_OP |-> op_code == 5'd0)
		else $error("op code on non-operator");

	// Errors carry a nonzero code
	a_errcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == cetl_pkg::K_ERROR |-> error_code != cetl_pkg::E_NONE)
		else $error("error without code");

endmodule

bind c_expression_token_lexer_unit cetl_check u_cetl_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.token_kind (token_kind),
	.op_code    (op_code),
	.error_code (error_code)
);
`default_nettype wire
